/* src/tmsx_pkg.sv */
// ----------------------------------------------------------------------------
// tmsx_pkg
// shared types and constants for the trie maximum subarray xor block
// ----------------------------------------------------------------------------
`default_nettype none

package tmsx_pkg;

    // width of the element and best_xor fields on the stream ports
    localparam int DATA_W = 32;

    // controller states
    typedef enum logic [3:0] {
        S_BOOT,
        S_BOOT_INS,
        S_IDLE,
        S_CLEAR,
        S_INS_ZERO,
        S_PREFIX,
        S_QUERY,
        S_BEST,
        S_INSERT,
        S_DONE
    } state_t;

    // commands from controller to datapath, at most one per cycle
    typedef struct packed {
        logic accept;     // latch element and start flag, clear full flag
        logic clear;      // empty trie, zero prefix and maximum, set up zero insert
        logic prefix;     // fold element into prefix, set up query walk
        logic qry_step;   // one query level
        logic best;       // update running maximum, set up insert walk
        logic ins_step;   // one insert level
        logic load_out;   // move result into output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic ins_last;   // this insert step ends the insert
        logic qry_last;   // this query step ends the query
        logic start;      // latched start flag of the current item
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

`default_nettype wire

/* src/trie_max_subarray_xor.sv */
// ----------------------------------------------------------------------------
// trie_max_subarray_xor
// running maximum subarray xor over a stream, using a binary trie of prefixes
// ----------------------------------------------------------------------------
// each item carries one array element, folded into a running prefix xor. the
// block walks a binary trie of all earlier prefixes of the pass, taking the
// opposite bit wherever a node has it, to get the largest xor of a subarray
// ending at this element; it returns the running maximum of the pass and then
// inserts the new prefix. the trie always holds the zero prefix. an item with
// the start flag set first empties the trie and zeroes prefix and maximum.
// an item makes one query walk and one insert walk, and a start item a second
// insert of zero, each walk taking one trie level per step. after reset the
// block inserts the zero prefix before it takes its first item. the store
// holds NODE_COUNT nodes; when it runs out an insert stops at that level and
// the result flags store_full. a finished result waits in an output register
// while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_max_subarray_xor #(
    parameter int VALUE_BITS = 32,     // trie depth, bits of the prefix
    parameter int NODE_COUNT = 32768   // node store depth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element
    input  wire logic        s_tuser,   // [0] start_pass
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] best_xor
    output logic             m_tuser    // [0] store_full
);

    tmsx_pkg::cmd_t cmd;
    tmsx_pkg::sts_t sts;

    // sequencer: boot insert, then per item clear, prefix, query, insert
    tmsx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // node store, walkers and result register
    tmsx_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_element (s_tdata),
        .in_start   (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_best   (m_tdata),
        .out_full   (m_tuser)
    );

    // the controller issues one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.clear, cmd.prefix, cmd.qry_step,
                  cmd.best, cmd.ins_step, cmd.load_out}))
        else $error("more than one datapath command");

    // an accepted item keeps the input closed until its result is loaded
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // loading a result always presents it on the output
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire

/* src/tmsx_ctrl.sv */
// ----------------------------------------------------------------------------
// tmsx_ctrl
// sequencer that steps the datapath through clear, query and insert walks
// ----------------------------------------------------------------------------
`default_nettype none

module tmsx_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tmsx_pkg::sts_t sts,
    output tmsx_pkg::cmd_t     cmd
);

    tmsx_pkg::state_t state_reg;
    tmsx_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmsx_pkg::S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmsx_pkg::S_BOOT:     state_next = tmsx_pkg::S_BOOT_INS;
            tmsx_pkg::S_BOOT_INS:
            begin
                if (sts.ins_last)
                begin
                    state_next = tmsx_pkg::S_IDLE;
                end
            end
            tmsx_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tmsx_pkg::S_CLEAR;
                end
            end
            tmsx_pkg::S_CLEAR:
            begin
                state_next = sts.start ? tmsx_pkg::S_INS_ZERO : tmsx_pkg::S_PREFIX;
            end
            tmsx_pkg::S_INS_ZERO:
            begin
                if (sts.ins_last)
                begin
                    state_next = tmsx_pkg::S_PREFIX;
                end
            end
            tmsx_pkg::S_PREFIX:   state_next = tmsx_pkg::S_QUERY;
            tmsx_pkg::S_QUERY:
            begin
                if (sts.qry_last)
                begin
                    state_next = tmsx_pkg::S_BEST;
                end
            end
            tmsx_pkg::S_BEST:     state_next = tmsx_pkg::S_INSERT;
            tmsx_pkg::S_INSERT:
            begin
                if (sts.ins_last)
                begin
                    state_next = tmsx_pkg::S_DONE;
                end
            end
            tmsx_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = tmsx_pkg::S_IDLE;
                end
            end
            default:              state_next = tmsx_pkg::S_BOOT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tmsx_pkg::S_BOOT:     cmd.clear = 1'b1;
            tmsx_pkg::S_BOOT_INS: cmd.ins_step = 1'b1;
            tmsx_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            // the clear state only does work on a start item
            tmsx_pkg::S_CLEAR:    cmd.clear = sts.start;
            tmsx_pkg::S_INS_ZERO: cmd.ins_step = 1'b1;
            tmsx_pkg::S_PREFIX:   cmd.prefix = 1'b1;
            tmsx_pkg::S_QUERY:    cmd.qry_step = 1'b1;
            tmsx_pkg::S_BEST:     cmd.best = 1'b1;
            tmsx_pkg::S_INSERT:   cmd.ins_step = 1'b1;
            tmsx_pkg::S_DONE:     cmd.load_out = sts.out_free;
            default:              cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/tmsx_dp.sv */
// ----------------------------------------------------------------------------
// tmsx_dp
// node store, trie walkers, prefix, running maximum and output register
// ----------------------------------------------------------------------------
`default_nettype none

module tmsx_dp #(
    parameter int VALUE_BITS = 32,
    parameter int NODE_COUNT = 32768
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tmsx_pkg::cmd_t              cmd,
    output tmsx_pkg::sts_t                   sts,
    input  wire logic [tmsx_pkg::DATA_W-1:0] in_element,
    input  wire logic                        in_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tmsx_pkg::DATA_W-1:0]      out_best,
    output logic                             out_full
);

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int USED_W  = $clog2(NODE_COUNT + 1);
    localparam int LVL_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int ENTRY_W = 2 * IDX_W;

    // node store: {child for bit 1, child for bit 0}; root lives in flops
    logic [ENTRY_W-1:0] mem [NODE_COUNT];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;

    logic [VALUE_BITS-1:0] elem_reg, prefix_reg, prefix_next, best_reg, best_next;
    logic [VALUE_BITS-1:0] ans_reg, ans_next, key_reg, key_next, elem_w;
    logic [IDX_W-1:0]      cur_reg, cur_next, root0_reg, root0_next, root1_reg, root1_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic                  chain_reg, chain_next, tail_reg, tail_next;
    logic                  start_reg, full_reg, full_next;
    logic                  out_valid_reg;
    logic [tmsx_pkg::DATA_W-1:0] out_best_reg, best_w;
    logic                  out_full_reg;
    logic                  ins_last, qry_last;

    logic [IDX_W-1:0] c0, c1, child, opp, new_idx;
    logic             bit_b, at_full, lvl_zero;

    // width adaptation between stream fields and trie values
    generate
        if (VALUE_BITS > tmsx_pkg::DATA_W)
        begin : g_wide
            assign elem_w = {{(VALUE_BITS - tmsx_pkg::DATA_W){1'b0}}, in_element};
            assign best_w = best_reg[tmsx_pkg::DATA_W-1:0];
        end
        else if (VALUE_BITS == tmsx_pkg::DATA_W)
        begin : g_same
            assign elem_w = in_element;
            assign best_w = best_reg;
        end
        else
        begin : g_narrow
            assign elem_w = in_element[VALUE_BITS-1:0];
            assign best_w = {{(tmsx_pkg::DATA_W - VALUE_BITS){1'b0}}, best_reg};
        end
    endgenerate

    assign c0       = (cur_reg == '0) ? root0_reg : rdata_reg[IDX_W-1:0];
    assign c1       = (cur_reg == '0) ? root1_reg : rdata_reg[ENTRY_W-1:IDX_W];
    assign bit_b    = key_reg[lvl_reg];
    assign child    = bit_b ? c1 : c0;
    assign opp      = bit_b ? c0 : c1;
    assign at_full  = (used_reg == USED_W'(NODE_COUNT));
    assign lvl_zero = (lvl_reg == '0);
    assign new_idx  = used_reg[IDX_W-1:0];

    always_comb
    begin
        prefix_next = prefix_reg;
        best_next   = best_reg;
        ans_next    = ans_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        lvl_next    = lvl_reg;
        used_next   = used_reg;
        chain_next  = chain_reg;
        tail_next   = tail_reg;
        root0_next  = root0_reg;
        root1_next  = root1_reg;
        full_next   = full_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = '0;
        ins_last    = 1'b0;
        qry_last    = 1'b0;

        if (cmd.accept)
        begin
            full_next = 1'b0;
        end

        // set up a walk from the root at the top level
        if (cmd.clear || cmd.prefix || cmd.best)
        begin
            cur_next   = '0;
            lvl_next   = LVL_W'(VALUE_BITS - 1);
            chain_next = 1'b0;
            tail_next  = 1'b0;
        end

        if (cmd.clear)
        begin
            root0_next  = '0;
            root1_next  = '0;
            used_next   = USED_W'(1);
            prefix_next = '0;
            best_next   = '0;
            key_next    = '0;
        end

        if (cmd.prefix)
        begin
            prefix_next = prefix_reg ^ elem_reg;
            key_next    = prefix_reg ^ elem_reg;
            ans_next    = '0;
        end

        if (cmd.best)
        begin
            if (ans_reg > best_reg)
            begin
                best_next = ans_reg;
            end
        end

        if (cmd.qry_step)
        begin
            // prefer the opposite bit, else follow the same bit, else stop
            if (opp != '0)
            begin
                ans_next[lvl_reg] = 1'b1;
                cur_next = opp;
            end
            else if (child != '0)
            begin
                cur_next = child;
            end
            else
            begin
                qry_last = 1'b1;
            end
            if (lvl_zero)
            begin
                qry_last = 1'b1;
            end
            else
            begin
                lvl_next = lvl_reg - LVL_W'(1);
            end
        end

        if (cmd.ins_step)
        begin
            if (!chain_reg)
            begin
                // walk existing nodes until a child is missing
                if (child != '0)
                begin
                    cur_next = child;
                    if (lvl_zero)
                    begin
                        ins_last = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                end
                else if (at_full)
                begin
                    full_next = 1'b1;
                    ins_last  = 1'b1;
                end
                else
                begin
                    // link the first new node into its existing parent
                    if (cur_reg == '0)
                    begin
                        if (bit_b)
                        begin
                            root1_next = new_idx;
                        end
                        else
                        begin
                            root0_next = new_idx;
                        end
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = bit_b ? {new_idx, c0} : {c1, new_idx};
                    end
                    used_next  = used_reg + USED_W'(1);
                    cur_next   = new_idx;
                    chain_next = 1'b1;
                    if (lvl_zero)
                    begin
                        tail_next = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                end
            end
            else
            begin
                // every node below a fresh one is fresh: write each once
                we = 1'b1;
                if (tail_reg)
                begin
                    ins_last = 1'b1;
                end
                else if (at_full)
                begin
                    full_next = 1'b1;
                    ins_last  = 1'b1;
                end
                else
                begin
                    wdata     = bit_b ? {new_idx, {IDX_W{1'b0}}} : {{IDX_W{1'b0}}, new_idx};
                    used_next = used_reg + USED_W'(1);
                    cur_next  = new_idx;
                    if (lvl_zero)
                    begin
                        tail_next = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                end
            end
        end
    end

    // node store ports; the read follows the node the walk moves to
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[cur_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= USED_W'(1);
            root0_reg     <= '0;
            root1_reg     <= '0;
            prefix_reg    <= '0;
            best_reg      <= '0;
            cur_reg       <= '0;
            lvl_reg       <= '0;
            chain_reg     <= 1'b0;
            tail_reg      <= 1'b0;
            full_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            root0_reg  <= root0_next;
            root1_reg  <= root1_next;
            prefix_reg <= prefix_next;
            best_reg   <= best_next;
            cur_reg    <= cur_next;
            lvl_reg    <= lvl_next;
            chain_reg  <= chain_next;
            tail_reg   <= tail_next;
            full_reg   <= full_next;
            if (cmd.accept)
            begin
                start_reg <= in_start;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ans_reg <= ans_next;
        key_reg <= key_next;
        if (cmd.accept)
        begin
            elem_reg <= elem_w;
        end
        if (cmd.load_out)
        begin
            out_best_reg <= best_w;
            out_full_reg <= full_reg;
        end
    end

    assign sts = '{ins_last: ins_last,
                   qry_last: qry_last,
                   start:    start_reg,
                   out_free: (!out_valid_reg || out_ready)};

    assign out_valid = out_valid_reg;
    assign out_best  = out_best_reg;
    assign out_full  = out_full_reg;

endmodule

`default_nettype wire

/* tb/tmsx_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsx_result_checker
// watches both streams of the trie maximum subarray xor block, predicts the
// best xor and store full flag of every accepted item, and compares results
// ----------------------------------------------------------------------------

module tmsx_result_checker #(
    parameter int VALUE_BITS = 32,
    parameter int NODE_COUNT = 32768
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [tmsx_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [tmsx_pkg::DATA_W-1:0] m_tdata,
    input  wire logic                        m_tuser,
    output int                               pending,
    output int                               mismatches,
    output int                               checked,
    output int                               full_hits
);

    localparam int DATA_W = tmsx_pkg::DATA_W;

    typedef struct packed {
        logic [DATA_W-1:0] best_xor;
        logic              store_full;
    } xor_result_t;

    localparam logic [DATA_W-1:0] PREFIX_MASK =
        (VALUE_BITS >= DATA_W) ? {DATA_W{1'b1}} :
                                 ((DATA_W'(1) << VALUE_BITS) - DATA_W'(1));

    // shadow trie: child index per bit, 0 means no child
    int unsigned       zero_kid [NODE_COUNT];
    int unsigned       one_kid  [NODE_COUNT];
    int unsigned       nodes_taken;
    logic [DATA_W-1:0] run_prefix;
    logic [DATA_W-1:0] run_best;

    xor_result_t       best_q[$];

    // returns 0 when the store ran out part way down
    function automatic logic trie_add(input logic [DATA_W-1:0] v);
        int unsigned node;
        int unsigned nxt;
        int          lvl;
        logic        ok;
        node = 0;
        ok   = 1'b1;
        for (lvl = VALUE_BITS - 1; lvl >= 0 && ok; lvl--) begin
            nxt = v[lvl] ? one_kid[node] : zero_kid[node];
            if (nxt == 0) begin
                if (nodes_taken >= NODE_COUNT) begin
                    ok = 1'b0;
                end else begin
                    nxt = nodes_taken;
                    nodes_taken++;
                    zero_kid[nxt] = 0;
                    one_kid[nxt]  = 0;
                    if (v[lvl])
                        one_kid[node] = nxt;
                    else
                        zero_kid[node] = nxt;
                end
            end
            node = nxt;
        end
        return ok;
    endfunction

    // greedy walk toward the opposite bit, stops early on a leaf
    function automatic logic [DATA_W-1:0] trie_best_match(input logic [DATA_W-1:0] v);
        int unsigned       node;
        int unsigned       opp;
        int unsigned       same;
        int                lvl;
        logic              walking;
        logic [DATA_W-1:0] acc;
        node    = 0;
        acc     = '0;
        walking = 1'b1;
        for (lvl = VALUE_BITS - 1; lvl >= 0 && walking; lvl--) begin
            opp  = v[lvl] ? zero_kid[node] : one_kid[node];
            same = v[lvl] ? one_kid[node] : zero_kid[node];
            if (opp != 0) begin
                acc[lvl] = 1'b1;
                node     = opp;
            end else if (same != 0) begin
                node = same;
            end else begin
                walking = 1'b0;
            end
        end
        return acc;
    endfunction

    function automatic logic restart_pass();
        nodes_taken = 1;
        zero_kid[0] = 0;
        one_kid[0]  = 0;
        run_prefix  = '0;
        run_best    = '0;
        return trie_add('0);
    endfunction

    function automatic xor_result_t predict_best(input logic [DATA_W-1:0] elem,
                                                 input logic start);
        xor_result_t       r;
        logic [DATA_W-1:0] cand;
        r.store_full = 1'b0;
        if (start && !restart_pass())
            r.store_full = 1'b1;
        run_prefix = (run_prefix ^ elem) & PREFIX_MASK;
        cand       = trie_best_match(run_prefix);
        if (cand > run_best)
            run_best = cand;
        if (!trie_add(run_prefix))
            r.store_full = 1'b1;
        r.best_xor = run_best;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xor_result_t want;
        if (!rst_n)
        begin
            void'(restart_pass());
            best_q.delete();
            pending    = 0;
            mismatches = 0;
            checked    = 0;
            full_hits  = 0;
        end
        else
        begin
            // results first: the item accepted at this edge cannot be the one leaving
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (m_tuser)
                    full_hits++;
                if (best_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d arrived with nothing outstanding: %h/%b",
                                 $realtime, checked, m_tdata, m_tuser);
                end
                else
                begin
                    want = best_q.pop_front();
                    if (m_tdata !== want.best_xor || m_tuser !== want.store_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result %0d: best exp %h got %h, full exp %b got %b",
                                     $realtime, checked, want.best_xor, m_tdata,
                                     want.store_full, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                best_q.push_back(predict_best(s_tdata, s_tuser));
            pending = best_q.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the trie maximum subarray xor block
// ----------------------------------------------------------------------------
// directed extremes and pass restarts first, then short random passes with a
// long receiver hold-off, one long pass that exhausts the node store, and more
// short passes after it; both streams idle at random, a checker predicts
// ----------------------------------------------------------------------------

module tb;

    localparam int DATA_W      = tmsx_pkg::DATA_W;
    localparam int VALUE_BITS  = 32;
    localparam int NODE_COUNT  = 32768;
    localparam int HOLD_CYCLES = 600;    // long receiver hold-off
    localparam int STUCK_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int TAIL_CYCLES = 120;    // settle time after the last drain
    localparam int LONG_PASS   = 1700;   // enough random prefixes to fill the store

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;    // [31:0] element
    logic              s_tuser;    // [0] start_pass
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;    // [31:0] best_xor
    logic              m_tuser;    // [0] store_full

    int                pending;
    int                mismatches;
    int                checked;
    int                full_hits;

    int                items_sent;
    int                passes_started;
    logic              steady;     // no idling on either side while set
    logic              hold_req;   // asks the receiver for one long hold-off

    trie_max_subarray_xor #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tmsx_result_checker #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .mismatches (mismatches),
        .checked    (checked),
        .full_hits  (full_hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 60)
            g = 0;
        else if (r < 92)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(10, 60);
        return g;
    endfunction

    // mix of shapes so prefixes share long paths as well as split early
    function automatic logic [DATA_W-1:0] pick_element();
        logic [DATA_W-1:0] e;
        case ($urandom_range(0, 6))
            0:       e = $urandom_range(0, 15);
            1:       e = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            2:       e = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            3:       e = $urandom & 32'hFFFF_0000;
            default: e = $urandom;
        endcase
        return e;
    endfunction

    // entered and left at a falling edge; holds tvalid high when there is no gap
    task automatic push_item(input logic [DATA_W-1:0] elem, input logic start);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (start)
            passes_started++;
    endtask

    // sender stops until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic short_passes(input int n, input int hold_at);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == hold_at)
            begin
                // keep offering back to back so the block fills behind the stall
                steady   = 1'b1;
                hold_req = 1'b1;
            end
            push_item(pick_element(), $urandom_range(0, 11) == 0);
        end
    endtask

    // receiver: random stalls, stretches of steady ready, one long hold-off
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = steady ? 0 : pick_gap();
            end
        end
    end

    // watchdog on cycles where no item moves
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("[%0t] no item moved for %0d cycles, %0d results outstanding",
                 $realtime, STUCK_LIMIT, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int i;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        steady         = 1'b0;
        hold_req       = 1'b0;
        items_sent     = 0;
        passes_started = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // the pass after reset needs no start item
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b0);
        push_item(32'h5555_5555, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        // restarts: on extremes, back to back, on a zero element
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h8000_0001, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'hFFFF_FFFE, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'hDEAD_BEEF, 1'b0);
        drain();

        short_passes(400, 120);
        drain();

        // one long pass: random prefixes run the node store dry, then the
        // inserts are cut short and later queries stop on truncated paths
        steady = 1'b0;
        push_item($urandom, 1'b1);
        for (i = 0; i < LONG_PASS; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            push_item($urandom, 1'b0);
        end
        drain();

        // a start must bring the store back from full
        steady = 1'b0;
        push_item(pick_element(), 1'b1);
        short_passes(200, -1);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items over %0d restarted passes, %0d results checked",
                 items_sent, passes_started, checked);
        $display("%0d results flagged a full node store, %0d mismatches",
                 full_hits, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
